>>> rtl/core/itbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbt_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package itbt_pkg;

  localparam int MAX_BASE     = 16;
  localparam int NUMBER_WIDTH = 32;
  localparam int ALPHA_BYTES  = 16;
  localparam int CHAR_W       = 8;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;

  // usable alphabet length
  localparam int ALPHA_CAP = (MAX_BASE < ALPHA_BYTES) ? MAX_BASE : ALPHA_BYTES;
  localparam int RADIX_W   = $clog2(ALPHA_CAP + 1);
  localparam int DIGIT_W   = $clog2(ALPHA_BYTES);
  localparam int REM_W     = RADIX_W + 1;

  // base 2 gives the most digits
  localparam int STACK_DEPTH = NUMBER_WIDTH;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;

  // floor(2^NUMBER_WIDTH / r); quotient estimate is low by at most one
  localparam logic [NUMBER_WIDTH-1:0] RECIP_TABLE [ALPHA_BYTES+1] = '{
    '0,
    '0,
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd2),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd3),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd4),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd5),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd6),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd7),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd8),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd9),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd10),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd11),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd12),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd13),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd14),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd15),
    NUMBER_WIDTH'((64'd1 << NUMBER_WIDTH) / 64'd16)
  };

  typedef struct packed {
    logic load;        // capture number and radix
    logic div_mul;     // reciprocal multiply
    logic div_fix;     // correct quotient, push digit
    logic emit_sign;   // send '-'
    logic emit_digit;  // pop and send one digit
  } itbt_cmd_t;

  typedef struct packed {
    logic radix_zero;    // alphabet rejected
    logic quot_zero;     // quotient in fix step is zero
    logic sign_pending;
    logic count_one;     // one digit left on stack
    logic out_free;      // output register can take a word
  } itbt_sts_t;

endpackage

>>> rtl/core/itbt_alpha.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbt_alpha
// Alphabet registers and radix check (length, sign chars, duplicates).
// ----------------------------------------------------------------------------
module itbt_alpha (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [itbt_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [itbt_pkg::CFG_DATA_W-1:0]             cfg_wdata_i,
  output logic [itbt_pkg::ALPHA_BYTES*itbt_pkg::CHAR_W-1:0] alphabet_o,
  output logic [itbt_pkg::RADIX_W-1:0]                radix_o
);
  import itbt_pkg::*;

  logic [CFG_DATA_W-1:0] alpha_low_q, alpha_high_q;
  logic [CHAR_W-1:0]     bytes [ALPHA_BYTES];
  logic [RADIX_W-1:0]    len;
  logic                  bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= '0;
      alpha_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA_LOW:  alpha_low_q  <= cfg_wdata_i;
        CFG_ALPHA_HIGH: alpha_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign alphabet_o = {alpha_high_q, alpha_low_q};

  always_comb begin
    for (int k = 0; k < ALPHA_BYTES; k++) begin
      bytes[k] = alphabet_o[k*CHAR_W +: CHAR_W];
    end
  end

  // length: first zero byte
  always_comb begin
    len = RADIX_W'(ALPHA_CAP);
    for (int k = ALPHA_CAP - 1; k >= 0; k--) begin
      if (bytes[k] == CHAR_NUL) len = RADIX_W'(k);
    end
  end

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < ALPHA_CAP; i++) begin
      if (RADIX_W'(i) < len) begin
        if (bytes[i] == CHAR_PLUS || bytes[i] == CHAR_MINUS) bad = 1'b1;
      end
      for (int j = i + 1; j < ALPHA_CAP; j++) begin
        if (RADIX_W'(j) < len && bytes[i] == bytes[j]) bad = 1'b1;
      end
    end
  end

  assign radix_o = (len < RADIX_W'(2) || bad) ? '0 : len;

endmodule

>>> rtl/core/itbt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbt_dp
// Datapath: magnitude, reciprocal divider, digit stack, output register.
// ----------------------------------------------------------------------------
module itbt_dp (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  itbt_pkg::itbt_cmd_t                               cmd_i,
  output itbt_pkg::itbt_sts_t                               sts_o,
  input  logic [itbt_pkg::NUMBER_WIDTH-1:0]                 number_i,
  input  logic [itbt_pkg::ALPHA_BYTES*itbt_pkg::CHAR_W-1:0] alphabet_i,
  input  logic [itbt_pkg::RADIX_W-1:0]                      radix_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic [itbt_pkg::CHAR_W-1:0]                       out_char_o,
  output logic                                              out_last_o
);
  import itbt_pkg::*;

  logic [NUMBER_WIDTH-1:0]   mag_q, mag_d;
  logic [RADIX_W-1:0]        radix_q;
  logic [2*NUMBER_WIDTH-1:0] prod_q;
  logic                      sign_q;
  logic [COUNT_W-1:0]        count_q;
  logic [DIGIT_W-1:0]        stack_q [STACK_DEPTH];

  logic                      valid_q;
  logic [CHAR_W-1:0]         char_q;
  logic                      last_q;

  logic [NUMBER_WIDTH-1:0]   quot0, quot;
  logic [REM_W+RADIX_W-1:0]  qr;
  logic [REM_W-1:0]          rem0, rem;
  logic                      ge;
  logic [DIGIT_W-1:0]        digit, top_digit;
  logic [COUNT_W-1:0]        count_m1;

  // magnitude from two's complement
  assign mag_d = number_i[NUMBER_WIDTH-1] ? (~number_i + 1'b1) : number_i;

  // quotient estimate is q or q-1; remainder < 2r fits in REM_W bits
  assign quot0 = prod_q[2*NUMBER_WIDTH-1:NUMBER_WIDTH];
  assign qr    = quot0[REM_W-1:0] * radix_q;
  assign rem0  = mag_q[REM_W-1:0] - qr[REM_W-1:0];
  assign ge    = rem0 >= {1'b0, radix_q};
  assign rem   = ge ? (rem0 - {1'b0, radix_q}) : rem0;
  assign quot  = quot0 + NUMBER_WIDTH'(ge);
  assign digit = rem[DIGIT_W-1:0];

  assign count_m1  = count_q - 1'b1;
  assign top_digit = stack_q[count_m1[PTR_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      sign_q  <= 1'b0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        mag_q   <= mag_d;
        sign_q  <= number_i[NUMBER_WIDTH-1];
        count_q <= '0;
      end
      if (cmd_i.div_fix) begin
        mag_q   <= quot;
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.emit_sign) sign_q <= 1'b0;
      if (cmd_i.emit_digit) count_q <= count_m1;
      if (cmd_i.emit_sign || cmd_i.emit_digit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) radix_q <= radix_i;
    if (cmd_i.div_mul) prod_q <= mag_q * RECIP_TABLE[radix_q];
    if (cmd_i.div_fix) stack_q[count_q[PTR_W-1:0]] <= digit;
    if (cmd_i.emit_sign) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= alphabet_i[top_digit*CHAR_W +: CHAR_W];
      last_q <= (count_q == COUNT_W'(1));
    end
  end

  assign sts_o.radix_zero   = (radix_q == '0);
  assign sts_o.quot_zero    = (quot == '0);
  assign sts_o.sign_pending = sign_q;
  assign sts_o.count_one    = (count_q == COUNT_W'(1));
  assign sts_o.out_free     = !valid_q || out_ready_i;

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

>>> rtl/core/itbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbt_ctrl
// Sequencer: load, check radix, divide loop, character emission.
// ----------------------------------------------------------------------------
module itbt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itbt_pkg::itbt_sts_t sts_i,
  output itbt_pkg::itbt_cmd_t cmd_o
);
  import itbt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_FIX,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = sts_i.radix_zero ? ST_IDLE : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.div_mul = 1'b1;
        state_d       = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.div_fix = 1'b1;
        state_d       = sts_i.quot_zero ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          if (sts_i.sign_pending) begin
            cmd_o.emit_sign = 1'b1;
          end else begin
            cmd_o.emit_digit = 1'b1;
            if (sts_i.count_one) state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = ready_q;

endmodule

>>> rtl/core/integer_to_base_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_base_text
// Signed integer to text in a radix set by a configured digit alphabet.
// ----------------------------------------------------------------------------
// One 32-bit signed word in, its text out as one character per word, the
// final character flagged by tlast. The alphabet (up to 16 bytes, registers
// 0 and 1, low byte first) ends at its first zero byte; its length is the
// radix. An alphabet shorter than two characters, or holding '+', '-' or a
// repeated character, is rejected and the number yields no output at all.
// Negative numbers start with '-'; the most negative value prints in full.
// Each item is loaded and its radix checked, then each digit goes
// through the reciprocal-multiply divider (one 32x32 multiply, then a
// correction step that pushes the remainder onto the digit stack), then the
// characters leave through the output register at one character per cycle
// while the output does not stall. The input is ready again once the last
// character is loaded into the output register, so the next word overlaps
// delivery of that character.
// The user must write configuration only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module integer_to_base_text (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [itbt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [itbt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic signed [31:0]                  s_axis_tdata,  // [31:0] number
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // [7:0] character
  output logic                                m_axis_tlast   // last
);
  import itbt_pkg::*;

  itbt_cmd_t                          cmd;
  itbt_sts_t                          sts;
  logic [ALPHA_BYTES*CHAR_W-1:0]      alphabet;
  logic [RADIX_W-1:0]                 radix;
  logic [NUMBER_WIDTH-1:0]            number;

  // only the low NUMBER_WIDTH bits take part
  assign number = s_axis_tdata[NUMBER_WIDTH-1:0];

  itbt_alpha u_alpha (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .alphabet_o  (alphabet),
    .radix_o     (radix)
  );

  itbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itbt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .number_i    (number),
    .alphabet_i  (alphabet),
    .radix_i     (radix),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // one number at a time: an accepted word closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still open after a word was accepted");

  // a character is only loaded when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_sign || cmd.emit_digit |-> sts.out_free)
    else $error("output register overwritten");

  // loading the final digit reopens the input and flags tlast
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_digit && sts.count_one |=> s_axis_tready && m_axis_tvalid && m_axis_tlast)
    else $error("final character not flagged or input not reopened");

endmodule
